// ===== rtl/rgb_box_blur_clipped_core_defines.svh =====
// assertion macros for the box blur core
`ifndef RGB_BOX_BLUR_CLIPPED_CORE_DEFINES_SVH
`define RGB_BOX_BLUR_CLIPPED_CORE_DEFINES_SVH

`ifndef SYNTH
`define RBB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rbb assertion failed");
`define RBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbb implication failed");
`else
`define RBB_ASSERT(label, clk, rst_n, prop)
`define RBB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rbb_pkg.sv =====
// shared types and constants of the box blur core
package rbb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RADIUS       = 3'd2;
    localparam logic [2:0] REG_FIRST_ROW    = 3'd3;
    localparam logic [2:0] REG_END_ROW      = 3'd4;

    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;
    localparam logic [3:0]  RADIUS_RST       = 4'd10;
    localparam logic [15:0] FIRST_ROW_RST    = 16'd0;
    localparam logic [15:0] END_ROW_RST      = 16'd480;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [15:0] row;
        logic [9:0]  column;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        frame_last;
    } out_item_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [15:0] image_height;
        logic [3:0]  radius;
        logic [15:0] first_row;
        logic [15:0] end_row;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } queue_ctl_t;

endpackage

// ===== rtl/rgb_box_blur_clipped_core.sv =====
// clipped box blur core: config registers, input queue and window engine
// a pixel word, taken only while the engine is idle, is divided into row and column, then stored
// an emitted pixel takes a position divide, one read of the single line store read port per
// in-image window pixel, then three colour divides on the one bit-serial divider (DN = 27)
// a window short of input or a drain with nothing to emit gives no result; queue holds two words
// reset clears positions and control; the line store is not cleared, no clearing pass
module rgb_box_blur_clipped_core
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  in_item_t              pix_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output out_item_t             res_data
);

`include "rgb_box_blur_clipped_core_defines.svh"

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    queue_ctl_t  q_ctl;
    logic        q_valid;
    logic        q_pop;
    in_item_t    q_data;
    logic [15:0] rows_h;
    logic [15:0] rows_end;
    logic        row_ok;
    logic        last_row_ok;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign q_ctl   = '{valid: q_valid, pop: q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= IMAGE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.radius       <= RADIUS_RST;
            cfg_reg.first_row    <= FIRST_ROW_RST;
            cfg_reg.end_row      <= END_ROW_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[15:0];
                REG_RADIUS:       cfg_reg.radius       <= pwdata[3:0];
                REG_FIRST_ROW:    cfg_reg.first_row    <= pwdata[15:0];
                REG_END_ROW:      cfg_reg.end_row      <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            REG_RADIUS:       prdata = APB_DATA_W'(cfg_reg.radius);
            REG_FIRST_ROW:    prdata = APB_DATA_W'(cfg_reg.first_row);
            REG_END_ROW:      prdata = APB_DATA_W'(cfg_reg.end_row);
            default:          prdata = '0;
        endcase
    end

    rbb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    rbb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_ctl_in  (q_ctl),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // emitted row range of a frame and its last row
    assign rows_h      = (cfg_reg.image_height == '0) ? 16'd1 : cfg_reg.image_height;
    assign rows_end    = (cfg_reg.end_row < rows_h) ? cfg_reg.end_row : rows_h;
    assign row_ok      = (res_data.row >= cfg_reg.first_row) && (res_data.row < rows_end);
    assign last_row_ok = (17'(res_data.row) + 17'd1 == 17'(rows_end));

    `RBB_ASSERT_IMPL(a_row_in_range, clk, rst_n, res_valid, row_ok)
    `RBB_ASSERT_IMPL(a_last_on_last_row, clk, rst_n, res_valid && res_data.frame_last, last_row_ok)
    `RBB_ASSERT(a_pop_needs_word, clk, rst_n, !q_pop || q_valid)

endmodule

// ===== rtl/rbb_front.sv =====
// input queue between the pixel port and the window engine
module rbb_front
    import rbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_ready,
    input  in_item_t   pix_data,
    input  logic       q_pop,
    output logic       q_valid,
    output in_item_t   q_data
);

    in_item_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push;
    logic                pop;

    assign pix_ready = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign q_valid   = (count_reg != '0);
    assign q_data    = entry_reg[rd_ptr_reg];
    assign push      = pix_valid && pix_ready;
    assign pop       = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= pix_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            // queue depth is a power of two, pointers wrap on their own
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/rbb_div.sv =====
// shared restoring divider, one quotient bit per cycle
module rbb_div
    import rbb_pkg::*;
#(
    parameter int DN = 27,
    parameter int DS = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DN-1:0] dividend,
    input  logic [DS-1:0] divisor,
    output logic          done,
    output logic [DN-1:0] quot,
    output logic [DS-1:0] rem
);

    localparam int CNT_W = $clog2(DN + 1);

    logic [DN-1:0]  quot_reg;
    logic [DS-1:0]  rem_reg;
    logic [DS-1:0]  den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DS:0]    trial;
    logic           fits;

    assign trial = {rem_reg, quot_reg[DN-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quot  = quot_reg;
    assign rem   = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DN-2:0], fits};
            rem_reg  <= fits ? DS'(trial - {1'b0, den_reg}) : DS'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg  <= CNT_W'(DN);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/rbb_back.sv =====
// window engine: line store, window sums, divides and result register
module rbb_back
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  queue_ctl_t q_ctl_in,
    output logic       q_pop,
    input  in_item_t   q_data,
    output logic       res_valid,
    input  logic       res_ready,
    output out_item_t  res_data
);

    localparam int LINES  = 2 * MAX_RADIUS + 2;
    localparam int WB     = $clog2(MAX_WIDTH + 1);
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int POS_W  = WB + 16;
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int LINE_W = $clog2(LINES);
    localparam int LCNT_W = $clog2(LINES + 1);
    localparam int WIN    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int SUM_W  = $clog2(WIN * 255 + 1);
    localparam int DN     = (POS_W > SUM_W) ? POS_W : SUM_W;
    localparam int DS0    = (WB > CNT_W) ? WB : CNT_W;
    localparam int DS     = (DS0 > LCNT_W) ? DS0 : LCNT_W;
    localparam int DEPTH  = LINES * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    // row to ring line by reciprocal multiply, exact for any 16-bit row
    localparam int     LDIV_SH = 16 + $clog2(LINES);
    localparam longint LDIV_M  = ((longint'(1) << LDIV_SH) + longint'(LINES) - 1)
                                 / longint'(LINES);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_DIVIN = 15'b000000000000010,
        ST_DIVLN = 15'b000000000000100,
        ST_CHECK = 15'b000000000001000,
        ST_DIVP  = 15'b000000000010000,
        ST_NEED  = 15'b000000000100000,
        ST_TEST  = 15'b000000001000000,
        ST_DIVR0 = 15'b000000010000000,
        ST_RD    = 15'b000000100000000,
        ST_ACC   = 15'b000001000000000,
        ST_DIVR  = 15'b000010000000000,
        ST_DIVG  = 15'b000100000000000,
        ST_DIVB  = 15'b001000000000000,
        ST_EMIT  = 15'b010000000000000,
        ST_END   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0]       mem [DEPTH];
    logic [23:0]       rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic [WB-1:0]     eff_w;
    logic [15:0]       eff_h;
    logic [RAD_W-1:0]  eff_r;
    logic [15:0]       hi_row;
    logic [POS_W-1:0]  total_reg;
    logic [POS_W-1:0]  lo_w_reg;
    logic [POS_W-1:0]  hi_w_reg;
    logic              rows_ok_reg;

    logic [POS_W-1:0]  in_pos_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [POS_W-1:0]  p_reg;
    logic [POS_W-1:0]  p_cur;
    logic [POS_W-1:0]  p_inc;
    logic              pending_reg;
    logic [23:0]       pix_reg;
    logic [WB-1:0]     pcol_reg;
    logic [15:0]       i_reg;
    logic [WB-1:0]     j_reg;
    logic [POS_W:0]    need_reg;
    logic [15:0]       r0_c, r1_c, r1_reg, rr_reg;
    logic [WB-1:0]     c0_c, c1_c, c0_reg, c1_reg, cc_reg;
    logic [16:0]       i_plus_r;
    logic [WB:0]       j_plus_r;
    logic [LINE_W-1:0] rline_reg;
    logic [SUM_W-1:0]  sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0]  sum_r_nx, sum_g_nx, sum_b_nx;
    logic [CNT_W-1:0]  cnt_reg, cnt_nx;
    logic [7:0]        red_reg, green_reg;

    logic [15:0]       row_src_reg;
    logic [15:0]       lq_reg;
    logic [LINE_W-1:0] line_c;
    logic              lstep_reg;

    logic              div_start_reg;
    logic              div_start_next;
    logic [DN-1:0]     div_a_reg;
    logic [DS-1:0]     div_b_reg;
    logic              div_done;
    logic [DN-1:0]     div_q;
    logic [DS-1:0]     div_r;

    logic              res_valid_reg;
    logic              emit_now;
    out_item_t         res_data_reg;

    // effective configuration
    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            eff_w = WB'(1);
        end
        else if (32'(cfg.image_width) > MAX_WIDTH)
        begin
            eff_w = WB'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WB'(cfg.image_width);
        end
        eff_h  = (cfg.image_height == '0) ? 16'd1 : cfg.image_height;
        eff_r  = (32'(cfg.radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(cfg.radius);
        hi_row = (cfg.end_row < eff_h) ? cfg.end_row : eff_h;
    end

    always_ff @(posedge clk)
    begin
        total_reg   <= POS_W'(POS_W'(eff_w) * POS_W'(eff_h));
        lo_w_reg    <= POS_W'(POS_W'(eff_w) * POS_W'(cfg.first_row));
        hi_w_reg    <= POS_W'(POS_W'(eff_w) * POS_W'(hi_row));
        rows_ok_reg <= (cfg.first_row < hi_row);
    end

    // window bounds, clipped at the image edges
    always_comb
    begin
        i_plus_r = 17'(i_reg) + 17'(eff_r);
        j_plus_r = (WB+1)'(j_reg) + (WB+1)'(eff_r);
        r0_c = (i_reg >= 16'(eff_r)) ? i_reg - 16'(eff_r) : 16'd0;
        r1_c = (i_plus_r > 17'(eff_h - 16'd1)) ? eff_h - 16'd1 : i_plus_r[15:0];
        c0_c = ((WB+1)'(j_reg) >= (WB+1)'(eff_r)) ? WB'(j_reg - WB'(eff_r)) : '0;
        c1_c = (j_plus_r > (WB+1)'(eff_w - WB'(1))) ? eff_w - WB'(1) : j_plus_r[WB-1:0];
    end

    // ring line of row_src_reg, valid in the cycle after row_src_reg, once lq_reg holds its quotient
    always_ff @(posedge clk)
    begin
        lq_reg <= 16'((40'(row_src_reg) * 40'(LDIV_M)) >> LDIV_SH);
    end

    assign line_c = LINE_W'(row_src_reg - 16'(32'(lq_reg) * 32'(LINES)));

    assign p_cur    = (out_pos_reg < lo_w_reg) ? lo_w_reg : out_pos_reg;
    assign p_inc    = p_reg + POS_W'(1);
    assign sum_r_nx = sum_r_reg + SUM_W'(rd_data_reg[23:16]);
    assign sum_g_nx = sum_g_reg + SUM_W'(rd_data_reg[15:8]);
    assign sum_b_nx = sum_b_reg + SUM_W'(rd_data_reg[7:0]);
    assign cnt_nx   = cnt_reg + CNT_W'(1);
    assign emit_now = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);

    assign q_pop   = (state_reg == ST_IDLE) && q_ctl_in.valid;
    assign mem_we  = (state_reg == ST_DIVLN) && lstep_reg;
    assign wr_addr = ADDR_W'(ADDR_W'(line_c) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(COL_W'(pcol_reg)));
    assign rd_addr = ADDR_W'(ADDR_W'(rline_reg) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(COL_W'(cc_reg)));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= pix_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    rbb_div #(
        .DN (DN),
        .DS (DS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_ctl_in.valid)
                begin
                    if (q_data.kind == KIND_PIXEL && in_pos_reg < total_reg)
                    begin
                        state_next = ST_DIVIN;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DIVIN: if (div_done) state_next = ST_DIVLN;
            ST_DIVLN: if (lstep_reg) state_next = ST_CHECK;
            ST_CHECK: state_next = (rows_ok_reg && p_cur < hi_w_reg) ? ST_DIVP : ST_END;
            ST_DIVP:  if (div_done) state_next = ST_NEED;
            ST_NEED:  state_next = ST_TEST;
            ST_TEST:  state_next = ((POS_W+1)'(in_pos_reg) > need_reg) ? ST_DIVR0 : ST_END;
            ST_DIVR0: if (lstep_reg) state_next = ST_RD;
            ST_RD:    state_next = ST_ACC;
            ST_ACC:   state_next = (cc_reg == c1_reg && rr_reg == r1_reg) ? ST_DIVR : ST_RD;
            ST_DIVR:  if (div_done) state_next = ST_DIVG;
            ST_DIVG:  if (div_done) state_next = ST_DIVB;
            ST_DIVB:  if (div_done) state_next = ST_EMIT;
            ST_EMIT:  if (!res_valid_reg || res_ready) state_next = ST_END;
            ST_END:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:          div_start_next = (state_next == ST_DIVIN);
            ST_CHECK:         div_start_next = (state_next == ST_DIVP);
            ST_ACC:           div_start_next = (state_next == ST_DIVR);
            ST_DIVR, ST_DIVG: div_start_next = div_done;
            default:          div_start_next = 1'b0;
        endcase
    end

    // datapath registers, loaded by state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                pix_reg   <= {q_data.red_in, q_data.green_in, q_data.blue_in};
                div_a_reg <= DN'(in_pos_reg);
                div_b_reg <= DS'(eff_w);
            end
            ST_DIVIN:
            begin
                pcol_reg    <= WB'(div_r);
                row_src_reg <= div_q[15:0];
            end
            ST_CHECK:
            begin
                p_reg     <= p_cur;
                div_a_reg <= DN'(p_cur);
                div_b_reg <= DS'(eff_w);
            end
            ST_DIVP:
            begin
                i_reg <= div_q[15:0];
                j_reg <= WB'(div_r);
            end
            ST_NEED:
            begin
                need_reg <= (POS_W+1)'(POS_W'(r1_c) * POS_W'(eff_w)) + (POS_W+1)'(c1_c);
                r1_reg   <= r1_c;
                c0_reg   <= c0_c;
                c1_reg   <= c1_c;
            end
            ST_TEST:
            begin
                rr_reg      <= r0_c;
                cc_reg      <= c0_c;
                sum_r_reg   <= '0;
                sum_g_reg   <= '0;
                sum_b_reg   <= '0;
                cnt_reg     <= '0;
                row_src_reg <= r0_c;
            end
            ST_DIVR0:
            begin
                rline_reg <= line_c;
            end
            ST_ACC:
            begin
                sum_r_reg <= sum_r_nx;
                sum_g_reg <= sum_g_nx;
                sum_b_reg <= sum_b_nx;
                cnt_reg   <= cnt_nx;
                div_a_reg <= DN'(sum_r_nx);
                div_b_reg <= DS'(cnt_nx);
                if (cc_reg == c1_reg)
                begin
                    cc_reg    <= c0_reg;
                    rr_reg    <= rr_reg + 16'd1;
                    rline_reg <= (rline_reg == LINE_W'(LINES - 1))
                                 ? '0 : rline_reg + LINE_W'(1);
                end
                else
                begin
                    cc_reg <= cc_reg + WB'(1);
                end
            end
            ST_DIVR:
            begin
                red_reg   <= div_q[7:0];
                div_a_reg <= DN'(sum_g_reg);
                div_b_reg <= DS'(cnt_reg);
            end
            ST_DIVG:
            begin
                green_reg <= div_q[7:0];
                div_a_reg <= DN'(sum_b_reg);
                div_b_reg <= DS'(cnt_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            res_data_reg.row        <= i_reg;
            res_data_reg.column     <= 10'(j_reg);
            res_data_reg.red_out    <= red_reg;
            res_data_reg.green_out  <= green_reg;
            res_data_reg.blue_out   <= div_q[7:0];
            res_data_reg.frame_last <= (p_inc == hi_w_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_pos_reg    <= '0;
            out_pos_reg   <= '0;
            pending_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            lstep_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            // ring line lookup step, set once lq_reg holds the quotient for line_c
            lstep_reg     <= ((state_reg == ST_DIVLN) || (state_reg == ST_DIVR0)) && !lstep_reg;
            if (emit_now)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_DIVLN:
                begin
                    if (lstep_reg)
                    begin
                        in_pos_reg <= in_pos_reg + POS_W'(1);
                    end
                end
                ST_CHECK:
                begin
                    pending_reg <= (state_next == ST_DIVP);
                end
                ST_EMIT:
                begin
                    if (emit_now)
                    begin
                        out_pos_reg   <= p_inc;
                        pending_reg   <= (p_inc < hi_w_reg);
                    end
                end
                ST_END:
                begin
                    // whole frame in and nothing left to emit: start over
                    if (in_pos_reg >= total_reg && !pending_reg)
                    begin
                        in_pos_reg  <= '0;
                        out_pos_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
